// ----- design/mcfir_pkg.sv -----
// mcfir_pkg: constants, codes, command/status structs and output scaling
// for the multichannel FIR filter. No dependencies.
`default_nettype none

package mcfir_pkg;

  localparam int MAX_TAPS     = 4096;
  localparam int CHANNELS     = 4;
  localparam int SAMPLE_WIDTH = 24;

  localparam int MODE_W      = 2;
  localparam int CHAN_W      = 2;
  localparam int COEF_IDX_W  = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int TAPCNT_W    = 13;

  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_AW   = CH_IDX_W + TAP_IDX_W;
  localparam int PROD_W    = 2 * SAMPLE_WIDTH;
  localparam int ACC_W     = PROD_W + TAP_IDX_W;
  localparam int FRAC_W    = SAMPLE_WIDTH - 1;
  localparam int Q_W       = ACC_W - FRAC_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT     = 1'd0,
    REG_FILTER_ENABLE = 1'd1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DONE  = 6'b010000,
    S_CLR   = 6'b100000
  } state_e;

  typedef struct packed {
    logic smp_wr;
    logic coef_wr;
    logic mac_issue;
    logic hist_clr;
    logic coef_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic run;
    logic k_last;
    logic pipe_busy;
    logic clr_last;
    logic out_busy;
  } sts_t;

  // floor shift by FRAC_W, then saturate to SAMPLE_WIDTH
  function automatic logic signed [SAMPLE_WIDTH-1:0] scale_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] qmax;
    logic signed [Q_W-1:0] qmin;
    qmax = {{(Q_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    qmin = ~qmax;
    q = acc[ACC_W-1:FRAC_W];
    if (q > qmax) begin
      scale_sat = qmax[SAMPLE_WIDTH-1:0];
    end else if (q < qmin) begin
      scale_sat = qmin[SAMPLE_WIDTH-1:0];
    end else begin
      scale_sat = q[SAMPLE_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/mcfir_ctrl.sv -----
// mcfir_ctrl: sequencing state machine for the multichannel FIR filter.
// Depends on mcfir_pkg; drives commands to mcfir_dp.
`default_nettype none

module mcfir_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mcfir_pkg::MODE_W-1:0]  mode_i,
  input  logic                          out_ready_i,
  input  mcfir_pkg::sts_t               sts_i,
  output mcfir_pkg::cmd_t               cmd_o
);
  import mcfir_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  mode_e  mode;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.hist_clr = 1'b1;
        cmd_o.coef_clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_FILTER: begin
              cmd_o.smp_wr = 1'b1;
              state_d = sts_i.run ? S_MAC : S_DONE;
            end
            MODE_COEF:  cmd_o.coef_wr = 1'b1;
            MODE_CLEAR: state_d = S_CLR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.k_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.hist_clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!sts_i.out_busy || out_ready_i))
    else $error("result loaded over an untaken one");

  a_clear_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode == MODE_CLEAR) |=> state_q == S_CLR)
    else $error("history clear not started");

  a_mac_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC && sts_i.k_last) |=> (state_q == S_DRAIN && !cmd_o.mac_issue))
    else $error("tap loop overran");

  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR || state_q == S_INIT) |-> !in_ready_o)
    else $error("input taken during sweep");

endmodule

`default_nettype wire

// ----- design/mcfir_dp.sv -----
// mcfir_dp: history and coefficient memories, MAC pipeline, config
// registers and output register. Depends on mcfir_pkg; driven by mcfir_ctrl.
`default_nettype none

module mcfir_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  mcfir_pkg::cmd_t                          cmd_i,
  output mcfir_pkg::sts_t                          sts_o,
  input  logic                                     cfg_valid_i,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [mcfir_pkg::CHAN_W-1:0]             channel_i,
  input  logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]         coef_index_i,
  input  logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] coef_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] filtered_o,
  output logic [mcfir_pkg::CHAN_W-1:0]             out_channel_o
);
  import mcfir_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] hist_mem [2**HIST_AW];
  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic [TAP_IDX_W-1:0]           wpos_q [CHANNELS];

  logic [TAPCNT_W-1:0]  tap_count_q;
  logic                 enable_q;
  logic [TAPCNT_W-1:0]  taps;
  logic [CH_IDX_W-1:0]  ch_in;
  logic [CH_IDX_W-1:0]  ch_q;
  logic [TAP_IDX_W-1:0] base_q;
  logic [TAP_IDX_W-1:0] k_q;
  logic [TAP_IDX_W-1:0] k_end_q;
  logic [HIST_AW-1:0]   clr_cnt_q;

  logic                 hist_we;
  logic [HIST_AW-1:0]   hist_waddr;
  logic signed [SAMPLE_WIDTH-1:0] hist_wdata;
  logic                 coef_we;
  logic [TAP_IDX_W-1:0] coef_waddr;
  logic signed [SAMPLE_WIDTH-1:0] coef_wdata;

  logic signed [SAMPLE_WIDTH-1:0] hist_rd_q, coef_rd_q;
  logic                 rd_vld_q, prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                 out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] filtered_q;
  logic [CHAN_W-1:0]    out_ch_q;

  assign ch_in = CH_IDX_W'(channel_i);
  assign taps  = (tap_count_q > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : tap_count_q;

  assign sts_o.run       = enable_q && (taps != '0);
  assign sts_o.k_last    = (k_q == k_end_q);
  assign sts_o.pipe_busy = rd_vld_q || prod_vld_q;
  assign sts_o.clr_last  = &clr_cnt_q;
  assign sts_o.out_busy  = out_valid_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
      enable_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TAP_COUNT:     tap_count_q <= cfg_data_i[TAPCNT_W-1:0];
        REG_FILTER_ENABLE: enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // memory write ports
  assign hist_we    = cmd_i.smp_wr || cmd_i.hist_clr;
  assign hist_waddr = cmd_i.hist_clr ? clr_cnt_q : {ch_in, wpos_q[ch_in]};
  assign hist_wdata = cmd_i.hist_clr ? '0 : sample_i;

  assign coef_we    = cmd_i.coef_clr ||
                      (cmd_i.coef_wr && ({1'b0, coef_index_i} < (COEF_IDX_W+1)'(MAX_TAPS)));
  assign coef_waddr = cmd_i.coef_clr ? clr_cnt_q[TAP_IDX_W-1:0] : TAP_IDX_W'(coef_index_i);
  assign coef_wdata = cmd_i.coef_clr ? '0 : coef_value_i;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_q <= hist_mem[{ch_q, base_q - k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    coef_rd_q <= coef_mem[k_q];
  end

  // sweep counter and write pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      for (int c = 0; c < CHANNELS; c++) wpos_q[c] <= '0;
    end else if (cmd_i.hist_clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      for (int c = 0; c < CHANNELS; c++) wpos_q[c] <= '0;
    end else if (cmd_i.smp_wr) begin
      wpos_q[ch_in] <= wpos_q[ch_in] + 1'b1;
    end
  end

  // per-item context
  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_wr) begin
      ch_q    <= ch_in;
      base_q  <= wpos_q[ch_in];
      k_end_q <= TAP_IDX_W'(taps - 1'b1);
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.mac_issue;
      prod_vld_q <= rd_vld_q;
      if (cmd_i.smp_wr) begin
        k_q <= '0;
      end else if (cmd_i.mac_issue) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_rd_q * hist_rd_q;
    if (cmd_i.smp_wr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filtered_q <= scale_sat(acc_q);
      out_ch_q   <= CHAN_W'(ch_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filtered_o    = filtered_q;
  assign out_channel_o = out_ch_q;

endmodule

`default_nettype wire

// ----- design/multichannel_fir_filter.sv -----
// multichannel_fir_filter: top level, controller plus datapath.
// Depends on mcfir_pkg, mcfir_ctrl and mcfir_dp.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/ready, mode, channel, sample,    | in
//           | coef_index, coef_value                    |
//  output   | out_valid/ready, filtered, out_channel    | out
//  config   | cfg_valid/ready, cfg_index, cfg_data      | in
//
// A filter transaction issues one MAC per tap on the shared multiplier, through
// a memory read and multiply pipeline; when disabled it skips the taps.
// A history clear sweeps the whole history memory. After reset a sweep
// clears history and coefficients with the input held off; config writes
// are always taken. A result waiting at the output stalls only the
// completion of the next one.
`default_nettype none

module multichannel_fir_filter (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [mcfir_pkg::MODE_W-1:0]              mode_i,
  input  logic [mcfir_pkg::CHAN_W-1:0]              channel_i,
  input  logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]          coef_index_i,
  input  logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] coef_value_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] filtered_o,
  output logic [mcfir_pkg::CHAN_W-1:0]              out_channel_o,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]          cfg_data_i
);
  import mcfir_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mcfir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcfir_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_o    (filtered_o),
    .out_channel_o (out_channel_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench for multichannel_fir_filter.
// Sends filter, coefficient, clear and no-op transactions, predicts every filter
// output internally and checks it field by field. Depends on mcfir_pkg and the design.

module tb;
  import mcfir_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int CLEAR_SETTLE   = MAX_TAPS * CHANNELS + 64;
  localparam int SHORT_SETTLE   = 32;
  localparam longint Q_HI = (64'sd1 <<< FRAC_W) - 1;
  localparam longint Q_LO = -Q_HI - 1;
  localparam logic [SAMPLE_WIDTH-1:0] POS_FULL = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] NEG_FULL = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] value;
    logic [CHAN_W-1:0]       chan;
  } fir_out_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [MODE_W-1:0]              mode_i;
  logic [CHAN_W-1:0]              channel_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic [COEF_IDX_W-1:0]          coef_index_i;
  logic signed [SAMPLE_WIDTH-1:0] coef_value_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [SAMPLE_WIDTH-1:0] filtered_o;
  logic [CHAN_W-1:0]              out_channel_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i;
  logic [CFG_DATA_W-1:0]          cfg_data_i;

  logic signed [SAMPLE_WIDTH-1:0] hist_mem [CHANNELS][MAX_TAPS];
  logic [TAP_IDX_W-1:0]           wr_ptr [CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic [TAPCNT_W-1:0]            taps_reg;
  logic                           enable_reg;

  fir_out_t expected_out[$];
  int       mismatches;
  int       settle_cycles;
  int       idle_cycles;
  bit       calm;

  multichannel_fir_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_o    (filtered_o),
    .out_channel_o (out_channel_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic clear_history_model();
    for (int c = 0; c < CHANNELS; c++) begin
      wr_ptr[c] = '0;
      for (int t = 0; t < MAX_TAPS; t++) hist_mem[c][t] = '0;
    end
  endtask

  // stores the sample, advances the ring and returns the saturated output
  function automatic logic [SAMPLE_WIDTH-1:0] fir_apply(
    input logic [CHAN_W-1:0]              ch,
    input logic signed [SAMPLE_WIDTH-1:0] smp
  );
    logic [TAP_IDX_W-1:0] pos;
    logic [TAP_IDX_W-1:0] slot;
    int                   taps;
    longint               acc;
    longint               q;
    pos = wr_ptr[ch];
    hist_mem[ch][pos] = smp;
    wr_ptr[ch] = pos + 1'b1;
    taps = (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
    if (!enable_reg || taps == 0) return '0;
    acc = 0;
    for (int k = 0; k < taps; k++) begin
      slot = pos - TAP_IDX_W'(k);
      acc += longint'(coef_mem[k]) * longint'(hist_mem[ch][slot]);
    end
    q = acc >>> FRAC_W;
    if (q > Q_HI) return POS_FULL;
    if (q < Q_LO) return NEG_FULL;
    return q[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] rand_q23();
    int near_zero;
    near_zero = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    case ($urandom_range(3))
      0: rand_q23 = near_zero[SAMPLE_WIDTH-1:0];
      1: rand_q23 = $urandom_range(1) ? POS_FULL : NEG_FULL;
      default: rand_q23 = SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_item(
    input mode_e                   m,
    input logic [CHAN_W-1:0]       ch,
    input logic [SAMPLE_WIDTH-1:0] smp,
    input logic [COEF_IDX_W-1:0]   ci,
    input logic [SAMPLE_WIDTH-1:0] cv
  );
    fir_out_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    channel_i    <= ch;
    sample_i     <= smp;
    coef_index_i <= ci;
    coef_value_i <= cv;
    do @(posedge clk_i); while (!in_ready_o);
    case (m)
      MODE_FILTER: begin
        predicted.value = fir_apply(ch, smp);
        predicted.chan  = ch;
        expected_out.push_back(predicted);
        settle_cycles = 0;
      end
      MODE_COEF: begin
        coef_mem[ci] = cv;
        if (settle_cycles < SHORT_SETTLE) settle_cycles = SHORT_SETTLE;
      end
      MODE_CLEAR: begin
        clear_history_model();
        settle_cycles = CLEAR_SETTLE;
      end
      default: begin
        if (settle_cycles < SHORT_SETTLE) settle_cycles = SHORT_SETTLE;
      end
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
    settle_cycles = 0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TAP_COUNT) taps_reg = data[TAPCNT_W-1:0];
    else enable_reg = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [TAPCNT_W-1:0] taps, input logic [CFG_DATA_W-1:0] en_word);
    wait_idle();
    write_reg(REG_TAP_COUNT, taps);
    write_reg(REG_FILTER_ENABLE, en_word);
  endtask

  // registers still at reset: outputs are zero, samples are stored anyway
  task automatic test_power_up();
    send_item(MODE_FILTER, 2'd0, POS_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd3, NEG_FULL, '1, POS_FULL);
    send_item(MODE_NONE, 2'd2, 24'h5A5A5A, 12'hA5A, 24'hA5A5A5);
  endtask

  task automatic test_saturation();
    configure(13'd2, 13'd1);
    send_item(MODE_COEF, 2'd1, '0, 12'd0, NEG_FULL);
    send_item(MODE_COEF, 2'd2, '1, 12'd1, NEG_FULL);
    send_item(MODE_COEF, 2'd0, '0, '1, POS_FULL);
    send_item(MODE_FILTER, 2'd1, NEG_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd1, NEG_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd2, POS_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd2, POS_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd3, 24'h000001, '0, '0);
  endtask

  task automatic test_disable_and_clear();
    configure(13'd2, 13'h1FFE);
    send_item(MODE_FILTER, 2'd1, 24'h400000, '0, '0);
    send_item(MODE_CLEAR, 2'd0, '0, '0, '0);
    configure(13'd2, 13'h0001);
    send_item(MODE_FILTER, 2'd1, POS_FULL, '0, '0);
  endtask

  task automatic test_zero_taps();
    configure(13'd0, 13'd1);
    send_item(MODE_FILTER, 2'd0, 24'h123456, '0, '0);
  endtask

  // tap counts above the maximum act as the maximum
  task automatic test_full_length();
    configure(13'h1FFF, 13'd1);
    send_item(MODE_FILTER, 2'd0, NEG_FULL, '0, '0);
    send_item(MODE_FILTER, 2'd0, POS_FULL, '0, '0);
    configure(13'h1000, 13'd1);
    send_item(MODE_FILTER, 2'd3, 24'h000100, '0, '0);
  endtask

  task automatic test_random_traffic();
    int                    items;
    int                    pick;
    mode_e                 m;
    logic [COEF_IDX_W-1:0] ci;
    for (int ph = 0; ph < 6; ph++) begin
      items = 24;
      calm  = (ph == 4);
      case (ph)
        0: configure(TAPCNT_W'($urandom_range(1, 8)), 13'd1);
        1: configure(TAPCNT_W'($urandom_range(9, 40)), CFG_DATA_W'($urandom) | 13'd1);
        2: configure(TAPCNT_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom) & ~13'd1);
        3: begin
          configure(TAPCNT_W'($urandom_range(4090, 8191)), 13'd1);
          items = 6;
        end
        4: configure(TAPCNT_W'($urandom_range(1, 24)), 13'd1);
        default: configure(TAPCNT_W'($urandom_range(0, 12)), 13'd1);
      endcase
      repeat (items) begin
        pick = $urandom_range(99);
        m = (pick < 68) ? MODE_FILTER : (pick < 93) ? MODE_COEF :
            (pick < 97) ? MODE_NONE : MODE_CLEAR;
        ci = (ph == 3 || $urandom_range(4) == 0) ? COEF_IDX_W'($urandom)
                                                  : COEF_IDX_W'($urandom_range(0, 63));
        send_item(m, CHAN_W'($urandom), rand_q23(), ci, rand_q23());
      end
    end
    calm = 1'b0;
  endtask

  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 10);

  always @(posedge clk_i) begin : check_output
    fir_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected output ch %0d value %h",
                                  out_channel_o, filtered_o));
      end else begin
        want = expected_out.pop_front();
        if (filtered_o !== want.value)
          report_mismatch($sformatf("filtered %h, want %h (ch %0d)",
                                    filtered_o, want.value, want.chan));
        if (out_channel_o !== want.chan)
          report_mismatch($sformatf("out_channel %0d, want %0d", out_channel_o, want.chan));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_NONE;
    channel_i     = '0;
    sample_i      = '0;
    coef_index_i  = '0;
    coef_value_i  = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_TAP_COUNT;
    cfg_data_i    = '0;
    calm          = 1'b0;
    mismatches    = 0;
    settle_cycles = 0;
    idle_cycles   = 0;
    taps_reg      = '0;
    enable_reg    = 1'b0;
    clear_history_model();
    for (int t = 0; t < MAX_TAPS; t++) coef_mem[t] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_power_up();
    test_saturation();
    test_disable_and_clear();
    test_zero_taps();
    test_full_length();
    test_random_traffic();

    wait_idle();
    repeat (SHORT_SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mcfir_pkg.sv
design/mcfir_ctrl.sv
design/mcfir_dp.sv
design/multichannel_fir_filter.sv
verif/tb.sv
